>>> rtl/i2cbm_pkg.sv
// shared types, command codes and phase helpers for the i2c bit-level master
`default_nettype none

package i2cbm_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned PHASE_W  = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd5;

    localparam logic [PHASE_W-1:0] WRITE_PHASES   = 5'd25;
    localparam logic [PHASE_W-1:0] READ_PHASES    = 5'd16;
    localparam logic [PHASE_W-1:0] WAITACK_PHASES = 5'd2;
    localparam logic [PHASE_W-1:0] OTHER_PHASES   = 5'd3;
    localparam logic [PHASE_W-1:0] WRITE_TAIL     = 5'd24;

    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_READ    = 3'd4,
        CMD_WAITACK = 3'd5,
        CMD_SENDACK = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        PART_SCL_LOW  = 2'd0,
        PART_SDA_BIT  = 2'd1,
        PART_SCL_HIGH = 2'd2
    } wr_part_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } pins_t;

    typedef struct packed {
        logic [2:0] bit_pos;
        wr_part_t   part;
    } wr_slot_t;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              nack;
        logic              rejected;
    } res_t;

    // write phases come in threes: scl low, data bit, scl high
    function automatic wr_slot_t write_slot(input logic [PHASE_W-1:0] idx);
        wr_slot_t s;
        s.bit_pos = 3'd0;
        s.part    = PART_SCL_LOW;
        for (int i = 0; i < 24; i++)
        begin
            if (idx == PHASE_W'(i))
            begin
                s.bit_pos = 3'(i / 3);
                s.part    = wr_part_t'(2'(i % 3));
            end
        end
        return s;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_total(input cmd_t c);
        logic [PHASE_W-1:0] n;
        unique case (c)
            CMD_WRITE:   n = WRITE_PHASES;
            CMD_READ:    n = READ_PHASES;
            CMD_WAITACK: n = WAITACK_PHASES;
            default:     n = OTHER_PHASES;
        endcase
        return n;
    endfunction

    // pin levels set on entry to a phase
    function automatic pins_t enter_phase(input pins_t p, input cmd_t c,
                                          input logic [PHASE_W-1:0] idx,
                                          input logic [BYTE_W-1:0] sh);
        pins_t    q;
        wr_slot_t s;
        q = p;
        s = write_slot(idx);
        unique case (c)
            CMD_START:
            begin
                q.drv = 1'b1;
                if (idx == 5'd0)
                begin
                    q.scl = 1'b1;
                    q.sda = 1'b1;
                end
                else if (idx == 5'd1)
                    q.sda = 1'b0;
                else
                    q.scl = 1'b0;
            end
            CMD_STOP:
            begin
                q.drv = 1'b1;
                if (idx == 5'd0)
                begin
                    q.scl = 1'b0;
                    q.sda = 1'b0;
                end
                else if (idx == 5'd1)
                    q.scl = 1'b1;
                else
                    q.sda = 1'b1;
            end
            CMD_WRITE:
            begin
                q.drv = 1'b1;
                if (idx >= WRITE_TAIL)
                    q.scl = 1'b0;
                else
                begin
                    unique case (s.part)
                        PART_SCL_LOW:  q.scl = 1'b0;
                        PART_SDA_BIT:  q.sda = sh[3'd7 - s.bit_pos];
                        PART_SCL_HIGH: q.scl = 1'b1;
                        default:       q.scl = p.scl;
                    endcase
                end
            end
            CMD_READ:
            begin
                q.drv = 1'b0;
                q.scl = ~idx[0];
            end
            CMD_WAITACK:
            begin
                q.drv = 1'b0;
                q.scl = (idx == 5'd0);
            end
            CMD_SENDACK:
            begin
                q.drv = 1'b1;
                if (idx == 5'd0)
                    q.sda = 1'b0;
                else if (idx == 5'd1)
                    q.scl = 1'b1;
                else
                    q.scl = 1'b0;
            end
            default:
            begin
                q = p;
            end
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2cbm_cmd_if.sv
// command channel: one tick item per transaction
`default_nettype none

interface i2cbm_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     command;
    logic [i2cbm_pkg::BYTE_W-1:0]   write_byte;
    logic                           sda_in;

    modport source (output valid, output command, output write_byte, output sda_in,
                    input ready);
    modport sink (input valid, input command, input write_byte, input sda_in,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/i2cbm_res_if.sv
// result channel: pin levels and status per transaction
`default_nettype none

interface i2cbm_res_if;
    logic                           valid;
    logic                           ready;
    logic                           scl_out;
    logic                           sda_out;
    logic                           sda_drive;
    logic                           busy_res;
    logic                           done_res;
    logic [i2cbm_pkg::BYTE_W-1:0]   read_byte;
    logic                           nack;
    logic                           rejected;

    modport source (output valid, output scl_out, output sda_out, output sda_drive,
                    output busy_res, output done_res, output read_byte, output nack,
                    output rejected, input ready);
    modport sink (input valid, input scl_out, input sda_out, input sda_drive,
                  input busy_res, input done_res, input read_byte, input nack,
                  input rejected, output ready);
endinterface

`default_nettype wire

>>> rtl/i2c_bit_level_master.sv
// i2c bit-level master: one tick item in, one pin/status result out
// Each accepted transaction on cmd_ch is one timing tick and yields exactly one
// result on res_ch; a new tick can be taken every clock cycle while the output
// register is empty or res_ch is ready. The engine state (phase counter, phase
// index, shift byte, pin levels) moves forward by one tick in short combinational
// logic, and the result sits in an output register that is refilled in the same
// cycle it is taken, so throughput is one tick per clock unless res_ch holds back.
// phase_ticks (cfg_we/cfg_wdata) sets the ticks per phase; 0 behaves as 1.
// Commands sent while a sequence runs are flagged in rejected and dropped.
`default_nettype none

module i2c_bit_level_master (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    i2cbm_cmd_if.sink                           cmd_ch,
    i2cbm_res_if.source                         res_ch,
    input  wire logic                           cfg_we,
    input  wire logic [i2cbm_pkg::TICK_W-1:0]   cfg_wdata
);

    logic [i2cbm_pkg::TICK_W-1:0]   phase_ticks_reg;
    logic [i2cbm_pkg::TICK_W-1:0]   tick_count_reg,  tick_count_next;
    logic [i2cbm_pkg::PHASE_W-1:0]  phase_index_reg, phase_index_next;
    i2cbm_pkg::cmd_t                active_reg,      active_next;
    logic [i2cbm_pkg::BYTE_W-1:0]   shift_reg,       shift_next;
    i2cbm_pkg::pins_t               pins_reg,        pins_next;
    logic                           nack_reg,        nack_next;
    logic [i2cbm_pkg::BYTE_W-1:0]   read_reg,        read_next;
    i2cbm_pkg::res_t                res_reg,         res_next;
    logic                           res_valid_reg;

    logic                           accept;
    logic [i2cbm_pkg::TICK_W-1:0]   limit;
    logic [i2cbm_pkg::TICK_W-1:0]   count_inc;
    logic                           rej;
    logic                           done;

    assign cmd_ch.ready = ~res_valid_reg | res_ch.ready;
    assign accept       = cmd_ch.valid & cmd_ch.ready;
    assign limit        = (phase_ticks_reg == '0) ? i2cbm_pkg::TICK_W'(1) : phase_ticks_reg;

    always_comb
    begin
        active_next      = active_reg;
        phase_index_next = phase_index_reg;
        tick_count_next  = tick_count_reg;
        shift_next       = shift_reg;
        pins_next        = pins_reg;
        nack_next        = nack_reg;
        read_next        = read_reg;
        rej              = 1'b0;
        done             = 1'b0;

        // take a new command only when idle
        if (active_reg == i2cbm_pkg::CMD_IDLE)
        begin
            if (cmd_ch.command >= i2cbm_pkg::CMD_START &&
                cmd_ch.command <= i2cbm_pkg::CMD_SENDACK)
            begin
                active_next      = i2cbm_pkg::cmd_t'(cmd_ch.command);
                phase_index_next = '0;
                tick_count_next  = '0;
                if (active_next == i2cbm_pkg::CMD_WRITE)
                    shift_next = cmd_ch.write_byte;
                pins_next = i2cbm_pkg::enter_phase(pins_reg, active_next, '0, shift_next);
            end
        end
        else if (cmd_ch.command != i2cbm_pkg::CMD_IDLE)
            rej = 1'b1;

        count_inc = tick_count_next + i2cbm_pkg::TICK_W'(1);

        if (active_next != i2cbm_pkg::CMD_IDLE)
        begin
            tick_count_next = count_inc;
            if (count_inc >= limit)
            begin
                // sample on the last tick of the phase
                if (active_next == i2cbm_pkg::CMD_READ && !phase_index_next[0])
                    shift_next = {shift_next[6:0], cmd_ch.sda_in};
                else if (active_next == i2cbm_pkg::CMD_WAITACK && phase_index_next == '0)
                    nack_next = cmd_ch.sda_in;
                tick_count_next  = '0;
                phase_index_next = phase_index_next + i2cbm_pkg::PHASE_W'(1);
                if (phase_index_next >= i2cbm_pkg::phase_total(active_next))
                begin
                    if (active_next == i2cbm_pkg::CMD_READ)
                        read_next = shift_next;
                    active_next      = i2cbm_pkg::CMD_IDLE;
                    phase_index_next = '0;
                    done             = 1'b1;
                end
                else
                    pins_next = i2cbm_pkg::enter_phase(pins_next, active_next,
                                                       phase_index_next, shift_next);
            end
        end
    end

    always_comb
    begin
        res_next.scl_out   = pins_next.scl;
        res_next.sda_out   = pins_next.sda;
        res_next.sda_drive = pins_next.drv;
        res_next.busy_res  = (active_next != i2cbm_pkg::CMD_IDLE);
        res_next.done_res  = done;
        res_next.read_byte = read_next;
        res_next.nack      = nack_next;
        res_next.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cbm_pkg::PHASE_TICKS_RST;
            tick_count_reg  <= '0;
            phase_index_reg <= '0;
            active_reg      <= i2cbm_pkg::CMD_IDLE;
            shift_reg       <= '0;
            pins_reg        <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            nack_reg        <= 1'b0;
            read_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                phase_ticks_reg <= cfg_wdata;
            if (accept)
            begin
                tick_count_reg  <= tick_count_next;
                phase_index_reg <= phase_index_next;
                active_reg      <= active_next;
                shift_reg       <= shift_next;
                pins_reg        <= pins_next;
                nack_reg        <= nack_next;
                read_reg        <= read_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res_ch.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res_ch.valid     = res_valid_reg;
    assign res_ch.scl_out   = res_reg.scl_out;
    assign res_ch.sda_out   = res_reg.sda_out;
    assign res_ch.sda_drive = res_reg.sda_drive;
    assign res_ch.busy_res  = res_reg.busy_res;
    assign res_ch.done_res  = res_reg.done_res;
    assign res_ch.read_byte = res_reg.read_byte;
    assign res_ch.nack      = res_reg.nack;
    assign res_ch.rejected  = res_reg.rejected;

endmodule

`default_nettype wire
